// ===== src/binary_to_decimal_ascii_defines.svh =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_defines
// Assertion macros shared by the converter modules.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// check a condition on every clock edge out of reset
`define BDA_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// check a consequence in the same cycle as its trigger
`define BDA_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== src/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg
// Shared widths, constants and helpers of the binary to decimal converter.
// ----------------------------------------------------------------------------
package bda_pkg;

   localparam int VALUE_W        = 31;
   localparam int CHAR_W         = 6;
   localparam int DIGIT_W        = 4;
   localparam int MAX_DIGITS_DEF = 10;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   // reciprocal of ten: q = (n * RECIP_TEN) >> RECIP_SHIFT, exact for 32-bit n
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam int          PROD_W      = VALUE_W + 32;

   localparam int POW_W = 64;

   function automatic logic [POW_W-1:0] pow10(input int k);
      logic [POW_W-1:0] p;
      p = POW_W'(1);
      for (int i = 0; i < k; i++) begin
         p = p * POW_W'(10);
      end
      return p;
   endfunction

endpackage

// ===== src/bda_channels.sv =====
// ----------------------------------------------------------------------------
// bda_channels
// Valid/ready channel interfaces for number requests and character responses.
// ----------------------------------------------------------------------------
interface bda_req_if import bda_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface bda_rsp_if import bda_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] digit_char;
   logic              last;

   modport source (output valid, output digit_char, output last, input ready);
   modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ===== src/bda_front.sv =====
// ----------------------------------------------------------------------------
// bda_front
// Accepts request transactions, counts decimal digits, registers the entry.
// ----------------------------------------------------------------------------
module bda_front import bda_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF,
   localparam int CNT_W = $clog2(MAX_DIGITS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   bda_req_if.sink            req_chan,
   output logic               ent_valid,
   input  logic               ent_ready,
   output logic [VALUE_W-1:0] ent_value,
   output logic [CNT_W-1:0]   ent_count
);

   logic               full_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               take;

   assign req_chan.ready = !full_ff || ent_ready;
   assign take           = req_chan.valid && req_chan.ready;

   // digit count, capped at MAX_DIGITS
   always_comb begin
      count_in = CNT_W'(1);
      for (int k = 1; k < MAX_DIGITS; k++) begin
         if ({(POW_W - VALUE_W)'(0), req_chan.value} >= pow10(k)) begin
            count_in = count_in + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (take) begin
         full_ff <= 1'b1;
      end else if (ent_ready) begin
         full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         value_ff <= req_chan.value;
         count_ff <= count_in;
      end
   end

   assign ent_valid = full_ff;
   assign ent_value = value_ff;
   assign ent_count = count_ff;

endmodule

// ===== src/bda_queue.sv =====
// ----------------------------------------------------------------------------
// bda_queue
// Short FIFO between the digit counter and the digit generator.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_defines.svh"

module bda_queue import bda_pkg::*; #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int OCC_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [OCC_W-1:0]  occ_ff;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (occ_ff != OCC_W'(DEPTH));
   assign pop_valid  = (occ_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            occ_ff <= occ_ff + OCC_W'(1);
         end else if (do_pop && !do_push) begin
            occ_ff <= occ_ff - OCC_W'(1);
         end
      end
   end

   `BDA_ASSERT_HOLDS(a_occ_bound, occ_ff <= OCC_W'(DEPTH), "queue occupancy past depth")

endmodule

// ===== src/bda_back.sv =====
// ----------------------------------------------------------------------------
// bda_back
// Splits a number into decimal digits and sends them as ASCII, MSB first.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_defines.svh"

module bda_back import bda_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF,
   localparam int CNT_W = $clog2(MAX_DIGITS + 1),
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               ent_valid,
   output logic               ent_ready,
   input  logic [VALUE_W-1:0] ent_value,
   input  logic [CNT_W-1:0]   ent_count,
   bda_rsp_if.source          rsp_chan
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_EMIT
   } state_type;

   localparam logic [CHAR_W-1:0] CHAR_MAX = ASCII_ZERO + CHAR_W'(DIGIT_MAX);

   state_type          state_ff;
   logic [VALUE_W-1:0] num_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   ptr_ff;
   logic [DIGIT_W-1:0] digit_buf_ff [MAX_DIGITS];
   logic               out_valid_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic               last_ff;

   logic [PROD_W-1:0]  prod;
   logic [VALUE_W-1:0] quot;
   logic [VALUE_W-1:0] rem_wide;
   logic [DIGIT_W-1:0] rem;
   logic               out_free;
   logic               char_ok;

   assign prod     = PROD_W'(num_ff) * PROD_W'(RECIP_TEN);
   assign quot     = VALUE_W'(prod[PROD_W-1:RECIP_SHIFT]);
   assign rem_wide = num_ff - (quot << 3) - (quot << 1);
   assign rem      = rem_wide[DIGIT_W-1:0];

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign ent_ready = (state_ff == S_IDLE);
   assign char_ok   = (char_ff >= ASCII_ZERO) && (char_ff <= CHAR_MAX);

   always_ff @(posedge clock) begin
      if (state_ff == S_DIV) begin
         digit_buf_ff[idx_ff] <= rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
         ptr_ff       <= '0;
         cnt_ff       <= CNT_W'(1);
      end else begin
         if (rsp_chan.ready && (state_ff != S_EMIT)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (ent_valid) begin
                  num_ff   <= ent_value;
                  cnt_ff   <= ent_count;
                  idx_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               num_ff <= quot;
               if (idx_ff == IDX_W'(cnt_ff - CNT_W'(1))) begin
                  ptr_ff   <= idx_ff;
                  state_ff <= S_EMIT;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  char_ff      <= ASCII_ZERO + CHAR_W'(digit_buf_ff[ptr_ff]);
                  last_ff      <= (ptr_ff == '0);
                  if (ptr_ff == '0) begin
                     state_ff <= S_IDLE;
                  end else begin
                     ptr_ff <= ptr_ff - IDX_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.digit_char = char_ff;
   assign rsp_chan.last       = last_ff;

   `BDA_ASSERT_IMPLIES(a_div_idx, state_ff == S_DIV, idx_ff < cnt_ff, "digit index past count")
   `BDA_ASSERT_IMPLIES(a_emit_ptr, state_ff == S_EMIT, ptr_ff < cnt_ff, "emit pointer past count")
   `BDA_ASSERT_IMPLIES(a_char_range, out_valid_ff, char_ok, "character not a decimal digit")

endmodule

// ===== src/binary_to_decimal_ascii.sv =====
// The generator runs the one-digit-per-cycle reciprocal divider followed by one character per
// cycle while the response channel is ready, and takes a new number only after its last character.
// A two-entry queue keeps accepting numbers while the generator works.
// Reset: synchronous, active high; clears all control state and drops queued numbers.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts unsigned binary numbers to ASCII decimal character streams.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii import bda_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bda_req_if.sink   req_chan,
   bda_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int ENT_W = CNT_W + VALUE_W;

   logic               fr_valid;
   logic               fr_ready;
   logic [VALUE_W-1:0] fr_value;
   logic [CNT_W-1:0]   fr_count;
   logic               bk_valid;
   logic               bk_ready;
   logic [ENT_W-1:0]   bk_data;

   bda_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .ent_valid (fr_valid),
      .ent_ready (fr_ready),
      .ent_value (fr_value),
      .ent_count (fr_count)
   );

   bda_queue #(.DATA_W(ENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  ({fr_count, fr_value}),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_data   (bk_data)
   );

   bda_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .ent_valid (bk_valid),
      .ent_ready (bk_ready),
      .ent_value (bk_data[VALUE_W-1:0]),
      .ent_count (bk_data[ENT_W-1:VALUE_W]),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== tb/tb_binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii
// Sends binary numbers to the converter and checks every ASCII digit that
// comes back, in order, against a digit predictor. Covers the field extremes,
// each decimal length boundary, random numbers of every length and a
// back-to-back stretch. Random bursts of idle cycles hit both channels.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii;
   import bda_pkg::*;

   localparam int unsigned RADIX = 10;
   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } ascii_char_type;

   logic clock;
   logic reset = 1'b1;
   bit   idle_on = 1'b1;
   int   errors = 0;
   int   stall_left = 0;

   ascii_char_type pending_chars[$];

   bda_req_if req_chan();
   bda_rsp_if rsp_chan();

   binary_to_decimal_ascii u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic void predict_number(input logic [VALUE_W-1:0] number);
      logic [DIGIT_W-1:0] digits [MAX_DIGITS_DEF];
      int unsigned rest;
      int count;
      ascii_char_type ch;
      rest = number;
      count = 0;
      do begin
         digits[count] = DIGIT_W'(rest % RADIX);
         rest = rest / RADIX;
         count++;
      end while (rest != 0 && count < MAX_DIGITS_DEF);
      for (int k = count - 1; k >= 0; k--) begin
         ch.digit_char = CHAR_W'(digits[k]) + ASCII_ZERO;
         ch.last = (k == 0);
         pending_chars.push_back(ch);
      end
   endfunction

   task automatic send_number(input logic [VALUE_W-1:0] number);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.value <= number;
      do @(posedge clock); while (!req_chan.ready);
      predict_number(number);
   endtask

   // check each transaction on the result channel; stall in random bursts
   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected char, expected none, actual %0d last=%0b",
                     $time, rsp_chan.digit_char, rsp_chan.last);
            errors++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_chan.digit_char !== want.digit_char) begin
               $display("%0t: digit_char mismatch, expected %0d, actual %0d",
                        $time, want.digit_char, rsp_chan.digit_char);
               errors++;
            end
            if (rsp_chan.last !== want.last) begin
               $display("%0t: last mismatch, expected %0b, actual %0b",
                        $time, want.last, rsp_chan.last);
               errors++;
            end
         end
      end
      if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 4);
      end
      if (!idle_on) begin
         stall_left = 0;
      end
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic test_extremes();
      send_number('0);
      send_number(VALUE_W'(1));
      send_number(VALUE_W'(9));
      send_number(VALUE_MAX);
      send_number(VALUE_W'(32'h2AAA_AAAA));
      send_number(VALUE_W'(32'h5555_5555));
      send_number(VALUE_W'(1_000_000_000));
   endtask

   task automatic test_length_boundaries();
      longint unsigned p;
      p = 1;
      for (int k = 1; k <= 9; k++) begin
         p = p * RADIX;
         send_number(VALUE_W'(p));
         if (k >= 2) begin
            send_number(VALUE_W'(p - 1));
         end
      end
   endtask

   task automatic test_random_lengths(input int count);
      longint unsigned p, lo, hi;
      int digits;
      for (int i = 0; i < count; i++) begin
         digits = $urandom_range(1, MAX_DIGITS_DEF);
         p = 1;
         repeat (digits - 1) p = p * RADIX;
         lo = (digits == 1) ? 0 : p;
         hi = p * RADIX - 1;
         if (hi > VALUE_MAX) begin
            hi = VALUE_MAX;
         end
         send_number(VALUE_W'($urandom_range(int'(hi), int'(lo))));
      end
   endtask

   task automatic test_random_full(input int count);
      for (int i = 0; i < count; i++) begin
         send_number(VALUE_W'($urandom()));
      end
   endtask

   task automatic test_back_to_back(input int count);
      idle_on = 1'b0;
      test_random_lengths(count);
   endtask

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_length_boundaries();
      test_random_lengths(180);
      test_random_full(40);
      test_back_to_back(40);
      req_chan.valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== binary_to_decimal_ascii.f =====
+incdir+src
src/bda_pkg.sv
src/bda_channels.sv
src/bda_front.sv
src/bda_queue.sv
src/bda_back.sv
src/binary_to_decimal_ascii.sv
tb/tb_binary_to_decimal_ascii.sv
